// ----- src/tmms_pkg.sv -----
// Shared types and constants of the temperature mux median sequencer.
package tmms_pkg;

    localparam int WINDOW_LEN_DEF  = 9;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int SAMPLE_W        = 12;
    localparam int VALUE_W         = 12;
    localparam int SRC_W           = 2;

    localparam logic [SRC_W-1:0] SRC_MOS1 = 2'd0;
    localparam logic [SRC_W-1:0] SRC_MOS2 = 2'd1;
    localparam logic [SRC_W-1:0] SRC_MOT1 = 2'd2;
    localparam logic [SRC_W-1:0] SRC_MOT2 = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic load;   // shift new sample into the selected window, start a pass
        logic run;    // rotate the circulating values one cell
        logic count;  // compare circulating value against own key
        logic motor;  // 0 motor 1 window, 1 motor 2 window
    } t_cell_ctrl;

endpackage

// ----- src/tmms_if.sv -----
// Valid/ready channel interfaces for sample input and result output.
interface tmms_in_if import tmms_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tmms_out_if import tmms_pkg::*;;
    logic               valid;
    logic               ready;
    logic [SRC_W-1:0]   src;
    logic [VALUE_W-1:0] value;
    logic [SRC_W-1:0]   next_select;

    modport source (output valid, output src, output value, output next_select, input ready);
    modport sink   (input valid, input src, input value, input next_select, output ready);
endinterface

// ----- src/tmms_cell.sv -----
// One window position of both motor rings plus its rank-count compare cell.
module tmms_cell import tmms_pkg::*; #(
    parameter int ENTRY_W  = SAMPLE_BITS_DEF,
    parameter int CNT_W    = 4,
    parameter int CELL_IDX = 0,
    parameter int MED_RANK = WINDOW_LEN_DEF / 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  logic [CNT_W-1:0]   i_step,
    input  logic [ENTRY_W-1:0] i_shift,
    input  logic [ENTRY_W-1:0] i_circ,
    output logic [ENTRY_W-1:0] o_ent,
    output logic [ENTRY_W-1:0] o_circ,
    output logic [ENTRY_W-1:0] o_key,
    output logic               o_hit
);

    logic [ENTRY_W-1:0] r_ent1;
    logic [ENTRY_W-1:0] r_ent2;
    logic [ENTRY_W-1:0] r_key;
    logic [ENTRY_W-1:0] r_circ;
    logic [CNT_W-1:0]   r_cnt;
    logic               below;

    // Equal values rank by position: an earlier cell ranks lower.
    assign below = (r_circ < r_key) ||
                   ((r_circ == r_key) && (i_step <= CNT_W'(CELL_IDX)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent1 <= '0;
            r_ent2 <= '0;
        end else if (i_ctrl.load) begin
            if (i_ctrl.motor) begin
                r_ent2 <= i_shift;
            end else begin
                r_ent1 <= i_shift;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_key  <= i_shift;
            r_circ <= i_shift;
            r_cnt  <= '0;
        end else if (i_ctrl.run) begin
            r_circ <= i_circ;
            if (i_ctrl.count && below) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_ent  = i_ctrl.motor ? r_ent2 : r_ent1;
    assign o_circ = r_circ;
    assign o_key  = r_key;
    assign o_hit  = (r_cnt == CNT_W'(MED_RANK));

endmodule

// ----- src/temp_mux_median_sequencer_unit.sv -----
// Results: a MOSFET sample goes into the output register on its transfer; a motor sample
// runs a rank pass (S_RUN, then S_DONE), and its median is registered once the output slot is free.
// Throughput: one item at a time; a motor item holds the block, with input not ready, through
// one full rotation of the window values around the cell chain for rank counting.
// Reset: synchronous, active low; phase returns to MOSFET 1 and both motor windows
// read as all zeros immediately, with no clearing pass.
module temp_mux_median_sequencer_unit import tmms_pkg::*; #(
    parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmms_in_if.sink     i_in,
    tmms_out_if.source  o_out
);

    localparam int ENTRY_W  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int CNT_W    = $clog2(WINDOW_LEN);
    localparam int MED_RANK = WINDOW_LEN / 2;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WINDOW_LEN - 1);

    t_state             r_state;
    t_state             n_state;
    logic [SRC_W-1:0]   r_phase;
    logic [SRC_W-1:0]   r_run_src;
    logic [CNT_W-1:0]   r_step;
    logic               r_ovld;
    logic [SRC_W-1:0]   r_osrc;
    logic [VALUE_W-1:0] r_oval;

    logic               in_xfer;
    logic               is_motor;
    logic               slot_free;
    logic               load_out;
    logic [ENTRY_W-1:0] sample_m;
    logic [ENTRY_W-1:0] median;
    t_cell_ctrl         ctrl;

    logic [ENTRY_W-1:0] ent   [WINDOW_LEN];
    logic [ENTRY_W-1:0] circ  [WINDOW_LEN];
    logic [ENTRY_W-1:0] key   [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] hit;

    assign sample_m  = i_in.sample[ENTRY_W-1:0];
    assign is_motor  = (r_phase == SRC_MOT1) || (r_phase == SRC_MOT2);
    assign slot_free = !r_ovld || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && (is_motor || slot_free);
    assign in_xfer   = i_in.valid && i_in.ready;
    assign load_out  = (in_xfer && !is_motor) || ((r_state == S_DONE) && slot_free);

    always_comb begin
        ctrl.load  = in_xfer && is_motor;
        ctrl.run   = (r_state == S_RUN);
        ctrl.count = (r_state == S_RUN) && (r_step != '0);
        ctrl.motor = ctrl.load ? (r_phase == SRC_MOT2) : (r_run_src == SRC_MOT2);
    end

    for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
        tmms_cell #(
            .ENTRY_W  (ENTRY_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (g),
            .MED_RANK (MED_RANK)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_step  (r_step),
            .i_shift ((g == 0) ? sample_m : ent[(g + WINDOW_LEN - 1) % WINDOW_LEN]),
            .i_circ  (circ[(g + WINDOW_LEN - 1) % WINDOW_LEN]),
            .o_ent   (ent[g]),
            .o_circ  (circ[g]),
            .o_key   (key[g]),
            .o_hit   (hit[g])
        );
    end

    // Exactly one cell holds the middle rank once the pass is done.
    always_comb begin
        median = '0;
        for (int k = 0; k < WINDOW_LEN; k++) begin
            median = median | (key[k] & {ENTRY_W{hit[k]}});
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && is_motor) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= SRC_MOS1;
            r_step  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_phase <= r_phase + 1'b1;
            end
            if (in_xfer) begin
                r_step <= '0;
            end else if (r_state == S_RUN) begin
                r_step <= r_step + 1'b1;
            end
            if (load_out) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_run_src <= r_phase;
        end
        if (load_out) begin
            if (r_state == S_DONE) begin
                r_osrc <= r_run_src;
                r_oval <= VALUE_W'(median);
            end else begin
                r_osrc <= r_phase;
                r_oval <= VALUE_W'(sample_m);
            end
        end
    end

    assign o_out.valid       = r_ovld;
    assign o_out.src         = r_osrc;
    assign o_out.value       = r_oval;
    assign o_out.next_select = r_osrc + 1'b1;

`ifndef SYNTHESIS
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_phase == SRC_W'($past(r_phase) + 1'b1)))
        else $error("phase did not advance by one on an input transfer");

    a_one_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> $onehot(hit))
        else $error("rank pass did not single out exactly one median cell");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RUN) && (r_step == LAST_STEP)) |=> (r_state == S_DONE))
        else $error("rank pass overran the window length");

    a_motor_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ((r_run_src == SRC_MOT1) || (r_run_src == SRC_MOT2)))
        else $error("rank pass ran for a non-motor source");
`endif

endmodule

// ----- verif/tb_temp_mux_median_sequencer_unit.sv -----
// Self-checking testbench: sequencer source order, MOSFET pass-through and motor ring medians.
module tb_temp_mux_median_sequencer_unit import tmms_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN        = WINDOW_LEN_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int RAND_ITEMS = 1800;

    typedef struct packed {
        logic [SRC_W-1:0]   source;
        logic [VALUE_W-1:0] value;
        logic [SRC_W-1:0]   next_select;
    } t_mux_reading;

    // Tracks phase and both motor rings, queues the reading each transfer should produce.
    class t_median_tracker;
        logic [SRC_W-1:0]   phase;
        logic [VALUE_W-1:0] motor_ring [2][WIN];
        int                 ring_slot [2];
        t_mux_reading       pending_readings [$];
        int                 mismatches;

        function new();
            phase = SRC_MOS1;
            for (int m = 0; m < 2; m++) begin
                ring_slot[m] = 0;
                for (int k = 0; k < WIN; k++) motor_ring[m][k] = '0;
            end
            mismatches = 0;
        endfunction

        function logic [VALUE_W-1:0] ring_median(int m);
            logic [VALUE_W-1:0] sorted [WIN];
            logic [VALUE_W-1:0] v;
            int j;
            for (int k = 0; k < WIN; k++) sorted[k] = motor_ring[m][k];
            for (int i = 1; i < WIN; i++) begin
                v = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > v) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            return sorted[WIN/2];
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] s);
            t_mux_reading r;
            int m;
            r.source = phase;
            if (phase == SRC_MOT1 || phase == SRC_MOT2) begin
                m = (phase == SRC_MOT1) ? 0 : 1;
                // overwrite the oldest entry, then advance the slot
                motor_ring[m][ring_slot[m]] = s;
                ring_slot[m] = (ring_slot[m] == WIN - 1) ? 0 : ring_slot[m] + 1;
                r.value = ring_median(m);
            end else begin
                r.value = s;
            end
            phase = phase + 1'b1;
            r.next_select = phase;
            pending_readings.push_back(r);
        endfunction

        function void match_result(t_mux_reading got);
            t_mux_reading exp_r;
            if (pending_readings.size() == 0) begin
                $display("%0t unexpected result: source %0d value %0d next_select %0d",
                         $time, got.source, got.value, got.next_select);
                mismatches++;
                return;
            end
            exp_r = pending_readings.pop_front();
            if (got.source !== exp_r.source) begin
                $display("%0t source mismatch: expected %0d actual %0d",
                         $time, exp_r.source, got.source);
                mismatches++;
            end
            if (got.value !== exp_r.value) begin
                $display("%0t value mismatch (source %0d): expected %0d actual %0d",
                         $time, exp_r.source, exp_r.value, got.value);
                mismatches++;
            end
            if (got.next_select !== exp_r.next_select) begin
                $display("%0t next_select mismatch: expected %0d actual %0d",
                         $time, exp_r.next_select, got.next_select);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_readings.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm;
    int   idle_cycles;

    tmms_in_if  in_ch ();
    tmms_out_if out_ch ();

    t_median_tracker tracker;

    temp_mux_median_sequencer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Hold valid across back-to-back transfers, drop it only for a gap.
    task automatic push_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    // Monitor both channels at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) tracker.take_sample(in_ch.sample);
            if (out_ch.valid && out_ch.ready)
                tracker.match_result({out_ch.src, out_ch.value, out_ch.next_select});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            out_ch.ready <= 1'b1;
            repeat (1 + $urandom_range(0, 7)) @(posedge i_clk);
            if (!calm) begin
                int gap;
                gap = pick_gap();
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        logic [SAMPLE_W-1:0] directed [$];
        logic [SAMPLE_W-1:0] s;
        int                  base;
        int                  r;

        tracker      = new();
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Rounds of four: MOSFET 1, MOSFET 2, motor 1, motor 2.
        // Early rounds mix zeros from reset into the medians; later ones repeat values.
        directed = '{12'h000, 12'hFFF, 12'hFFF, 12'h000,
                     12'hAAA, 12'h555, 12'h001, 12'hFFE,
                     12'h555, 12'hAAA, 12'hFFF, 12'hFFF,
                     12'h800, 12'h7FF, 12'hFFF, 12'h800,
                     12'h123, 12'hEDC, 12'hFFF, 12'h800,
                     12'hFFF, 12'h000, 12'h7FF, 12'h800,
                     12'h001, 12'h002, 12'h7FF, 12'h7FF};
        foreach (directed[k]) push_sample(directed[k]);

        base = 2048;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                s = SAMPLE_W'($urandom_range(0, 4095));
            end else if (r < 60) begin
                case ($urandom_range(0, 5))
                    0: s = 12'h000;
                    1: s = 12'hFFF;
                    2: s = 12'h001;
                    3: s = 12'hFFE;
                    4: s = 12'h800;
                    default: s = 12'h7FF;
                endcase
            end else begin
                // slowly drifting reading, gives duplicates and close ranks in the rings
                base = base + int'($urandom_range(0, 40)) - 20;
                if (base < 0) base = 0;
                if (base > 4095) base = 4095;
                s = SAMPLE_W'(base + int'($urandom_range(0, 3)));
            end
            push_sample(s);
        end
        in_ch.valid <= 1'b0;
        calm = 1'b0;

        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (WIN + 6) @(posedge i_clk);

        if (tracker.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
